>>> hw/rtl/ptzcf_pkg.sv
// Shared types and constants of the pan/tilt/zoom command framer.
`timescale 1ns / 1ps

package ptzcf_pkg;

  // Field and datapath widths
  localparam int unsigned ANGLE_W = 13;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned ZOOM_W  = 13;
  localparam int unsigned DVD_W   = 24;
  localparam int unsigned DSR_W   = 14;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_W   = 9;

  typedef enum logic [1:0] {
    MODE_MOVE = 2'd0,
    MODE_PAN  = 2'd1,
    MODE_TILT = 2'd2,
    MODE_ZOOM = 2'd3
  } ptzcf_mode_e;

  typedef enum logic [1:0] {
    CFG_PAN_MIN  = 2'd0,
    CFG_PAN_MAX  = 2'd1,
    CFG_TILT_MIN = 2'd2,
    CFG_TILT_MAX = 2'd3
  } ptzcf_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SETUP,
    ST_START,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } ptzcf_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic setup;
    logic div_start;
    logic fix;
    logic axis;
    logic idx_inc;
  } ptzcf_cmd_t;

  typedef struct packed {
    logic is_zoom;
    logic div_done;
    logic idx_last;
  } ptzcf_sts_t;

  // Frame bytes
  localparam logic [7:0] BYTE_SYNC      = 8'hFF;
  localparam logic [7:0] BYTE_ADDR_HI   = 8'h30;
  localparam logic [7:0] BYTE_ADDR_LO   = 8'h31;
  localparam logic [7:0] BYTE_PAD       = 8'h00;
  localparam logic [7:0] BYTE_END       = 8'hEF;
  localparam logic [7:0] CMD_PAN_SPEED  = 8'h50;
  localparam logic [7:0] CMD_TILT_SPEED = 8'h51;
  localparam logic [7:0] CMD_POSITION   = 8'h62;
  localparam logic [7:0] CMD_ZOOM_SPEED = 8'hB4;
  localparam logic [7:0] CMD_ZOOM_POS   = 8'hB3;
  localparam logic [7:0] ZOOM_SPEED_ARG = 8'h31;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;
  localparam logic [7:0] ASCII_LETTER   = 8'h37;

  // Last byte index of each request kind
  localparam logic [IDX_W-1:0] MOVE_LAST_IDX = 5'd31;
  localparam logic [IDX_W-1:0] ZOOM_LAST_IDX = 5'd17;

  // Device codes
  localparam logic [15:0] PAN_HI      = 16'h8379;
  localparam logic [15:0] PAN_LO      = 16'h7C87;
  localparam logic [15:0] TILT_HI     = 16'h810B;
  localparam logic [15:0] TILT_LO     = 16'h7EF5;
  localparam logic [15:0] POS_CENTER  = 16'h8000;
  localparam logic [10:0] PAN_SPAN    = 11'h6F2;
  localparam logic [10:0] TILT_SPAN   = 11'h216;
  localparam logic [11:0] PAN_SPEED_CAP  = 12'h320;
  localparam logic [11:0] TILT_SPEED_CAP = 12'h26E;
  localparam logic [11:0] SPEED_OFFSET   = 12'd8;
  // 5/9 as 36410 / 2^16; exact floor for all 12-bit speeds
  localparam logic [15:0] SPEED_RECIP    = 16'd36410;
  localparam logic [11:0] ZOOM_CAP       = 12'h7A8;
  localparam logic [2:0]  ZOOM_RATE_CAP  = 3'd7;
  localparam logic [3:0]  ZOOM_RATE_MUL  = 4'd7;

  // Reset values
  localparam logic [8:0]  PAN_MIN_RST  = 9'h151;   // -175
  localparam logic [7:0]  PAN_MAX_RST  = 8'd175;
  localparam logic [7:0]  TILT_MIN_RST = 8'hC9;    // -55
  localparam logic [6:0]  TILT_MAX_RST = 7'd90;
  localparam logic [SPEED_W-1:0] SPEED_RST      = 12'd800;
  localparam logic [ZOOM_W-1:0]  ZOOM_LEVEL_RST = 13'd2048;
  localparam logic [ZOOM_W-1:0]  ZOOM_RATE_RST  = 13'd4096;

endpackage

>>> hw/rtl/pan_tilt_zoom_command_framer_unit.sv
// Top level of the pan/tilt/zoom command framer: controller, datapath and checks.
// A move request prepares the speed codes, runs two position divisions in the
// shared one-bit-per-cycle divider, then sends 32 bytes at one byte per cycle
// while the output is taken.
// A zoom request prepares its codes, then sends 18 bytes.
// Reset restores the limit registers and held state to their defaults at once.
`timescale 1ns / 1ps

module pan_tilt_zoom_command_framer_unit import ptzcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [SPEED_W-1:0] pan_speed_i,
  input  logic [ANGLE_W-1:0] pan_angle_i,
  input  logic [SPEED_W-1:0] tilt_speed_i,
  input  logic [ANGLE_W-1:0] tilt_angle_i,
  input  logic [ZOOM_W-1:0]  zoom_rate_i,
  input  logic [ZOOM_W-1:0]  zoom_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic               frame_end_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  ptzcf_cmd_t cmd;
  ptzcf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptzcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ptzcf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .pan_speed_i  (pan_speed_i),
    .pan_angle_i  (pan_angle_i),
    .tilt_speed_i (tilt_speed_i),
    .tilt_angle_i (tilt_angle_i),
    .zoom_rate_i  (zoom_rate_i),
    .zoom_level_i (zoom_level_i),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o),
    .last_o       (last_o)
  );

  // Input and output never open together: one request is handled at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a word is being delivered");

  // The final word of a request is always a frame terminator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> frame_end_o)
    else $error("last word is not a frame terminator");

  // An accepted request closes the input until its words are delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input stayed open after a request was taken");

  // Taking the final word returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (in_ready_o && !out_valid_o))
    else $error("block did not return to idle after the final word");

endmodule

>>> hw/rtl/ptzcf_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps

module ptzcf_div import ptzcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             rem_nz_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;

  logic [DSR_W:0] rem_sh;
  logic [DSR_W:0] diff;
  logic           fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    diff   = rem_sh - {1'b0, divisor_i};
    fits   = (rem_sh >= {1'b0, divisor_i});

    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign rem_nz_o   = (rem_q != '0);
  assign done_o     = done_q;

endmodule

>>> hw/rtl/ptzcf_dp.sv
// Datapath: limit registers, held request state, device codes and byte selection.
`timescale 1ns / 1ps

module ptzcf_dp import ptzcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptzcf_cmd_t         cmd_i,
  output ptzcf_sts_t         sts_o,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic [1:0]         mode_i,
  input  logic [SPEED_W-1:0] pan_speed_i,
  input  logic [ANGLE_W-1:0] pan_angle_i,
  input  logic [SPEED_W-1:0] tilt_speed_i,
  input  logic [ANGLE_W-1:0] tilt_angle_i,
  input  logic [ZOOM_W-1:0]  zoom_rate_i,
  input  logic [ZOOM_W-1:0]  zoom_level_i,
  output logic [7:0]         frame_byte_o,
  output logic               frame_end_o,
  output logic               last_o
);

  function automatic logic [7:0] hex_ascii(input logic [3:0] d);
    logic [7:0] base;
    base = (d < 4'd10) ? ASCII_ZERO : ASCII_LETTER;
    return base + {4'b0, d};
  endfunction

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a,
                                                     input logic signed [13:0] lo,
                                                     input logic signed [13:0] hi);
    logic signed [13:0] v;
    v = $signed({a[ANGLE_W-1], a});
    if (v < lo) v = lo;
    if (hi < v) v = hi;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic [11:0] speed_code(input logic [SPEED_W-1:0] s,
                                             input logic [11:0] cap);
    logic [27:0] p;
    logic [11:0] c;
    p = 28'(s) * 28'(SPEED_RECIP);
    c = p[27:16] + SPEED_OFFSET;
    return (c > cap) ? cap : c;
  endfunction

  // Limit registers
  logic [8:0] pan_min_q;
  logic [7:0] pan_max_q;
  logic [7:0] tilt_floor_q;
  logic [6:0] tilt_ceil_q;

  // Held request state
  logic [1:0]         mode_q;
  logic [ANGLE_W-1:0] held_pan_angle_q, held_tilt_angle_q;
  logic [SPEED_W-1:0] held_pan_speed_q, held_tilt_speed_q;
  logic [ZOOM_W-1:0]  held_zoom_rate_q, held_zoom_level_q;

  // Codes
  logic [11:0] psc_q, tsc_q;
  logic [2:0]  rc_q;
  logic [10:0] lc_q;
  logic [15:0] px_q, ty_q;
  logic [IDX_W-1:0] idx_q;

  // Division operands
  logic             num_neg_q, den_neg_q, r_zero_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DSR_W-1:0] dsr_q;

  logic [DVD_W-1:0] quo;
  logic             rem_nz;
  logic             div_done;

  logic signed [13:0] pan_lo16, pan_hi16, tilt_lo16, tilt_hi16;
  logic signed [9:0]  pan_r, tilt_r;
  logic [SPEED_W-1:0] ps_sel, ts_sel;
  logic [ANGLE_W-1:0] pa_sel, ta_sel;

  always_comb begin
    pan_lo16  = $signed({pan_min_q[8], pan_min_q, 4'b0});
    pan_hi16  = $signed({2'b0, pan_max_q, 4'b0});
    tilt_lo16 = $signed({{2{tilt_floor_q[7]}}, tilt_floor_q, 4'b0});
    tilt_hi16 = $signed({3'b0, tilt_ceil_q, 4'b0});
    pan_r     = $signed({2'b0, pan_max_q}) - $signed({pan_min_q[8], pan_min_q});
    tilt_r    = $signed({3'b0, tilt_ceil_q}) - $signed({{2{tilt_floor_q[7]}}, tilt_floor_q});
    ps_sel    = (mode_i != MODE_TILT) ? pan_speed_i  : held_pan_speed_q;
    pa_sel    = (mode_i != MODE_TILT) ? pan_angle_i  : held_pan_angle_q;
    ts_sel    = (mode_i != MODE_PAN)  ? tilt_speed_i : held_tilt_speed_q;
    ta_sel    = (mode_i != MODE_PAN)  ? tilt_angle_i : held_tilt_angle_q;
  end

  // Position numerator 2*a*L + 16*R, split into sign and magnitude
  logic [ANGLE_W-1:0] a_sel;
  logic [10:0]        l_sel;
  logic signed [9:0]  r_sel;
  logic signed [24:0] prod;
  logic signed [25:0] num;
  logic [25:0]        num_mag;
  logic [9:0]         r_abs;

  always_comb begin
    a_sel   = cmd_i.axis ? held_tilt_angle_q : held_pan_angle_q;
    l_sel   = cmd_i.axis ? TILT_SPAN : PAN_SPAN;
    r_sel   = cmd_i.axis ? tilt_r : pan_r;
    prod    = $signed({{12{a_sel[ANGLE_W-1]}}, a_sel}) * $signed({14'b0, l_sel});
    num     = $signed({prod[24], prod}) * 26'sd2 + $signed({{12{r_sel[9]}}, r_sel, 4'b0});
    num_mag = num[25] ? 26'(-num) : 26'(num);
    r_abs   = r_sel[9] ? 10'(-r_sel) : 10'(r_sel);
  end

  // Floor correction and clamp of the position code
  logic [25:0]        q_ext;
  logic signed [25:0] q_s, p_s, lo_s, hi_s;
  logic [15:0]        pos;

  always_comb begin
    q_ext = {2'b0, quo};
    q_s   = (num_neg_q ^ den_neg_q) ? $signed(-(q_ext + 26'(rem_nz))) : $signed(q_ext);
    p_s   = $signed({10'b0, POS_CENTER}) + q_s;
    lo_s  = $signed({10'b0, cmd_i.axis ? TILT_LO : PAN_LO});
    hi_s  = $signed({10'b0, cmd_i.axis ? TILT_HI : PAN_HI});
    if (p_s < lo_s) p_s = lo_s;
    if (hi_s < p_s) p_s = hi_s;
    pos = r_zero_q ? POS_CENTER : p_s[15:0];
  end

  // Zoom codes
  logic [15:0] rate_prod;
  logic [23:0] level_prod;
  logic [2:0]  rc;
  logic [10:0] lc;

  always_comb begin
    rate_prod  = 16'(held_zoom_rate_q) * 16'(ZOOM_RATE_MUL);
    level_prod = 24'(held_zoom_level_q) * 24'(ZOOM_CAP);
    rc = (rate_prod[15:12] > {1'b0, ZOOM_RATE_CAP}) ? ZOOM_RATE_CAP : rate_prod[14:12];
    lc = (level_prod[23:12] > ZOOM_CAP) ? ZOOM_CAP[10:0] : level_prod[22:12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_min_q         <= PAN_MIN_RST;
      pan_max_q         <= PAN_MAX_RST;
      tilt_floor_q      <= TILT_MIN_RST;
      tilt_ceil_q       <= TILT_MAX_RST;
      mode_q            <= MODE_MOVE;
      held_pan_angle_q  <= '0;
      held_tilt_angle_q <= '0;
      held_pan_speed_q  <= SPEED_RST;
      held_tilt_speed_q <= SPEED_RST;
      held_zoom_rate_q  <= ZOOM_RATE_RST;
      held_zoom_level_q <= ZOOM_LEVEL_RST;
      idx_q             <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PAN_MIN:  pan_min_q    <= cfg_data_i[8:0];
          CFG_PAN_MAX:  pan_max_q    <= cfg_data_i[7:0];
          CFG_TILT_MIN: tilt_floor_q <= cfg_data_i[7:0];
          CFG_TILT_MAX: tilt_ceil_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        mode_q <= mode_i;
        idx_q  <= '0;
        if (mode_i == MODE_ZOOM) begin
          held_zoom_rate_q  <= zoom_rate_i;
          held_zoom_level_q <= zoom_level_i;
        end else begin
          held_pan_speed_q  <= ps_sel;
          held_tilt_speed_q <= ts_sel;
          held_pan_angle_q  <= clamp_angle(pa_sel, pan_lo16, pan_hi16);
          held_tilt_angle_q <= clamp_angle(ta_sel, tilt_lo16, tilt_hi16);
        end
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      psc_q <= speed_code(held_pan_speed_q, PAN_SPEED_CAP);
      tsc_q <= speed_code(held_tilt_speed_q, TILT_SPEED_CAP);
      rc_q  <= rc;
      lc_q  <= lc;
    end
    if (cmd_i.setup) begin
      num_neg_q <= num[25];
      den_neg_q <= r_sel[9];
      r_zero_q  <= (r_sel == '0);
      dvd_q     <= num_mag[DVD_W-1:0];
      dsr_q     <= {r_abs[8:0], 5'b0};
    end
    if (cmd_i.fix) begin
      if (cmd_i.axis) ty_q <= pos;
      else            px_q <= pos;
    end
  end

  ptzcf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_q),
    .divisor_i  (dsr_q),
    .quotient_o (quo),
    .rem_nz_o   (rem_nz),
    .done_o     (div_done)
  );

  // Byte selection by position within the request
  logic [7:0] byte_sel;
  logic       is_zoom;

  always_comb begin
    is_zoom = (mode_q == MODE_ZOOM);
    if (is_zoom) begin
      case (idx_q)
        5'd0, 5'd8:         byte_sel = BYTE_SYNC;
        5'd1, 5'd9:         byte_sel = BYTE_ADDR_HI;
        5'd2, 5'd10:        byte_sel = BYTE_ADDR_LO;
        5'd3, 5'd11:        byte_sel = BYTE_PAD;
        5'd4:               byte_sel = CMD_ZOOM_SPEED;
        5'd5:               byte_sel = ZOOM_SPEED_ARG;
        5'd6:               byte_sel = hex_ascii({1'b0, rc_q});
        5'd12:              byte_sel = CMD_ZOOM_POS;
        5'd13:              byte_sel = hex_ascii(4'b0);
        5'd14:              byte_sel = hex_ascii({1'b0, lc_q[10:8]});
        5'd15:              byte_sel = hex_ascii(lc_q[7:4]);
        5'd16:              byte_sel = hex_ascii(lc_q[3:0]);
        default:            byte_sel = BYTE_END;
      endcase
    end else begin
      case (idx_q)
        5'd0, 5'd9, 5'd18:  byte_sel = BYTE_SYNC;
        5'd1, 5'd10, 5'd19: byte_sel = BYTE_ADDR_HI;
        5'd2, 5'd11, 5'd20: byte_sel = BYTE_ADDR_LO;
        5'd3, 5'd12, 5'd21: byte_sel = BYTE_PAD;
        5'd4:               byte_sel = CMD_PAN_SPEED;
        5'd5:               byte_sel = hex_ascii(psc_q[11:8]);
        5'd6:               byte_sel = hex_ascii(psc_q[7:4]);
        5'd7:               byte_sel = hex_ascii(psc_q[3:0]);
        5'd13:              byte_sel = CMD_TILT_SPEED;
        5'd14:              byte_sel = hex_ascii(tsc_q[11:8]);
        5'd15:              byte_sel = hex_ascii(tsc_q[7:4]);
        5'd16:              byte_sel = hex_ascii(tsc_q[3:0]);
        5'd22:              byte_sel = CMD_POSITION;
        5'd23:              byte_sel = hex_ascii(px_q[15:12]);
        5'd24:              byte_sel = hex_ascii(px_q[11:8]);
        5'd25:              byte_sel = hex_ascii(px_q[7:4]);
        5'd26:              byte_sel = hex_ascii(px_q[3:0]);
        5'd27:              byte_sel = hex_ascii(ty_q[15:12]);
        5'd28:              byte_sel = hex_ascii(ty_q[11:8]);
        5'd29:              byte_sel = hex_ascii(ty_q[7:4]);
        5'd30:              byte_sel = hex_ascii(ty_q[3:0]);
        default:            byte_sel = BYTE_END;
      endcase
    end
  end

  assign frame_byte_o   = byte_sel;
  assign frame_end_o    = (byte_sel == BYTE_END);
  assign last_o         = sts_o.idx_last;
  assign sts_o.is_zoom  = is_zoom;
  assign sts_o.div_done = div_done;
  assign sts_o.idx_last = (idx_q == (is_zoom ? ZOOM_LAST_IDX : MOVE_LAST_IDX));

endmodule

>>> hw/rtl/ptzcf_ctrl.sv
// Controller: sequences code preparation, the two position divisions of a move request and byte output.
`timescale 1ns / 1ps

module ptzcf_ctrl import ptzcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ptzcf_cmd_t cmd_o,
  input  ptzcf_sts_t sts_i
);

  ptzcf_state_e state_q, state_d;
  logic         axis_q, axis_d;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        axis_d  = 1'b0;
        state_d = sts_i.is_zoom ? ST_EMIT : ST_SETUP;
      end
      ST_SETUP: state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_FIX;
      end
      ST_FIX: begin
        if (axis_q) begin
          state_d = ST_EMIT;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_SETUP;
        end
      end
      ST_EMIT: begin
        if (out_ready_i && sts_i.idx_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:  cmd_o.prep      = 1'b1;
      ST_SETUP: cmd_o.setup     = 1'b1;
      ST_START: cmd_o.div_start = 1'b1;
      ST_FIX:   cmd_o.fix       = 1'b1;
      ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.idx_inc = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule
